@@ hdl/pfc_pkg.sv @@
// Shared types, codes and frame tables of the peripheral bus poll controller.
package pfc_pkg;

  // Reply byte store.
  localparam int STORE_BYTES = 32;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam logic [7:0] STORE_LIMIT = 8'(STORE_BYTES);

  // Reply byte counter saturates here; a saturated count is an overlong frame.
  localparam logic [6:0] COUNT_MAX = 7'd127;

  // Header bytes kept in flops for the frame checks.
  localparam int HDR_BYTES = 6;

  // Input operation codes.
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [1:0] STATUS_REJECTED = 2'd2;
  localparam logic [1:0] STATUS_IGNORED  = 2'd3;

  // Poll modes.
  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_CTRL  = 2'd1;
  localparam logic [1:0] MODE_KBD   = 2'd2;
  localparam logic [1:0] MODE_MOUSE = 2'd3;

  // Present-function mask bits.
  localparam logic [2:0] HAS_CTRL  = 3'b001;
  localparam logic [2:0] HAS_KBD   = 3'b010;
  localparam logic [2:0] HAS_MOUSE = 3'b100;

  // Frame header values.
  localparam logic [7:0] CMD_INFO_REPLY = 8'h1c;
  localparam logic [7:0] CMD_INFO_REQ   = 8'h01;
  localparam logic [7:0] CMD_GET_COND   = 8'h09;
  localparam logic [7:0] HOST_ADDR      = 8'h20;
  localparam logic [7:0] INFO_REPLY_CMD = 8'h05;
  localparam logic [7:0] COND_REPLY_CMD = 8'h08;
  localparam logic [7:0] FUNC_CTRL_LO   = 8'h01;
  localparam logic [7:0] FUNC_KBD_LO    = 8'h40;
  localparam logic [7:0] FUNC_MOUSE_HI  = 8'h02;
  localparam logic [7:0] COND_CSUM_SEED = 8'h28;
  localparam logic [7:0] INFO_CSUM      = 8'h21;

  localparam logic [6:0] PROBE_MIN_LEN = 7'd52;
  localparam logic [6:0] COND_MIN_LEN  = 7'd9;
  localparam logic [7:0] CTRL_PAY_LEN  = 8'd3;
  localparam logic [7:0] MOUSE_PAY_LEN = 8'd6;

  // Outgoing frame and report lengths.
  localparam logic [3:0] PROBE_FRAME_LEN = 4'd5;
  localparam logic [3:0] COND_FRAME_LEN  = 4'd9;
  localparam logic [4:0] SHORT_RPT_LEN   = 5'd9;
  localparam logic [4:0] MOUSE_RPT_LEN   = 5'd21;

  // Report id bytes and adjustments.
  localparam logic [7:0] RPT_ID_CTRL  = 8'd1;
  localparam logic [7:0] RPT_ID_KBD   = 8'd2;
  localparam logic [7:0] RPT_ID_MOUSE = 8'd3;
  localparam logic [7:0] SIGN_FLIP    = 8'h80;
  localparam logic [7:0] WHEEL_HI     = 8'h02;
  localparam logic [5:0] RPT_BASE     = 6'd8;

  typedef struct packed {
    logic       operation;
    logic [7:0] data;
    logic       last;
    logic       report_busy;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       end_of_run;
  } out_item_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic       is_status;
    logic [1:0] mode;
    logic [1:0] status;
    logic       report;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  // First present function of the mask, or of the whole present set when empty.
  function automatic logic [1:0] choose_mode(input logic [2:0] funcs,
                                             input logic [2:0] present);
    logic [2:0] g;
    logic [1:0] m;
    g = (funcs == 3'b000) ? present : funcs;
    if ((g & HAS_CTRL) != 3'b000) m = MODE_CTRL;
    else if ((g & HAS_KBD) != 3'b000) m = MODE_KBD;
    else if ((g & HAS_MOUSE) != 3'b000) m = MODE_MOUSE;
    else m = MODE_PROBE;
    return m;
  endfunction

  // Byte idx of the command frame sent for a poll in the given mode.
  function automatic logic [7:0] frame_byte(input logic [1:0] mode, input logic [3:0] idx);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    lo = 8'h00;
    hi = 8'h00;
    if (mode == MODE_CTRL) lo = FUNC_CTRL_LO;
    else if (mode == MODE_KBD) lo = FUNC_KBD_LO;
    else hi = FUNC_MOUSE_HI;
    b = 8'h00;
    if (mode == MODE_PROBE) begin
      case (idx)
        4'd2:    b = HOST_ADDR;
        4'd3:    b = CMD_INFO_REQ;
        4'd4:    b = INFO_CSUM;
        default: b = 8'h00;
      endcase
    end else begin
      case (idx)
        4'd0:    b = CMD_INFO_REQ;
        4'd2:    b = HOST_ADDR;
        4'd3:    b = CMD_GET_COND;
        4'd4:    b = lo;
        4'd5:    b = hi;
        4'd8:    b = COND_CSUM_SEED ^ hi ^ lo;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

@@ hdl/peripheral_bus_poll_controller.sv @@
// Top level of the peripheral bus poll controller: front, job queue and back.
//
//   Channel  Handshake            Payload    Moves
//   req      req_valid/req_ready  in_item_t  one poll or one received reply byte
//   rsp      rsp_valid/rsp_ready  out_item_t one frame, status or report byte
//
// A reply byte that is not the last one is taken and gives no result.
// A poll queues a job; the back sends its 5-byte or 9-byte command frame at one
// byte per cycle while rsp is not stalled. A last reply byte queues a status job;
// each report byte after it, up to 21 bytes, is a store read, then an output load.
// While a report is pending or running the front holds req_ready low, since the
// back reads the reply store. Reset clears mode, function set, count and control.
// A stalled rsp side fills the queue (two jobs) and then stalls the req side.
module peripheral_bus_poll_controller import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  logic      push;
  job_t      push_job;
  logic      pop;
  job_t      head;
  logic      q_full;
  logic      q_empty;
  store_wr_t wr;
  logic      report_done;

  // The front classifies each item and decides the frame outcome at once.
  pfc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job),
    .wr          (wr),
    .report_done (report_done)
  );

  // Short queue so the front keeps taking items while results drain.
  pfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back owns the reply store and the output register.
  pfc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .pop         (pop),
    .head        (head),
    .wr          (wr),
    .report_done (report_done),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp)
  );

endmodule

@@ hdl/pfc_queue.sv @@
// Two-entry job queue between the front and the back.
module pfc_queue import pfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
  end

endmodule

@@ hdl/pfc_front.sv @@
// Front part: takes items, buffers reply bytes, checks frames and queues jobs.
module pfc_front import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  in_item_t  req,
  input  logic      q_full,
  output logic      push,
  output job_t      push_job,
  output store_wr_t wr,
  input  logic      report_done
);

  logic [1:0] mode;
  logic [2:0] present;
  logic [6:0] count;
  logic [7:0] xsum;
  logic [7:0] hdr [HDR_BYTES];
  logic       lock;

  logic        accept;
  logic        is_byte;
  logic [6:0]  count_inc;
  logic [6:0]  n;
  logic [7:0]  hn [HDR_BYTES];
  logic [7:0]  xor_next;
  logic [10:0] len_expect;
  logic [2:0]  funcs;
  logic        found;
  logic        acc;
  logic        ok;
  logic [1:0]  mode_next;
  logic [2:0]  present_next;

  // The back reads report bytes from the store, so new items wait until it is done.
  assign req_ready = !q_full && !lock;
  assign accept    = req_valid && req_ready;
  assign is_byte   = (req.operation == OP_BYTE);

  assign wr.en   = accept && is_byte && ({1'b0, count} < STORE_LIMIT);
  assign wr.addr = count[STORE_AW-1:0];
  assign wr.data = req.data;

  assign count_inc = (count == COUNT_MAX) ? count : count + 7'd1;
  assign n         = (count_inc == COUNT_MAX) ? 7'd0 : count_inc;
  assign xor_next  = xsum ^ req.data;

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hn[i] = (count == 7'(i)) ? req.data : hdr[i];
    end
  end

  assign len_expect = {1'b0, hn[0], 2'b00} + 11'd5;
  assign funcs = {hn[5][1], hn[4][6], hn[4][0]};

  assign found = (n >= PROBE_MIN_LEN) && (hn[0] == CMD_INFO_REPLY) &&
                 (hn[1] == HOST_ADDR) && (hn[2] == 8'h00) && (hn[3] == INFO_REPLY_CMD);
  assign acc = (n >= COND_MIN_LEN) && (len_expect == {4'b0000, n}) &&
               (xor_next == 8'h00) && (hn[1] == HOST_ADDR) && (hn[2] == 8'h00) &&
               (hn[3] == COND_REPLY_CMD);

  always_comb begin
    mode_next    = mode;
    present_next = present;
    ok           = 1'b0;
    push_job.is_status = (req.operation == OP_BYTE);
    push_job.mode      = mode;
    push_job.status    = STATUS_IGNORED;
    push_job.report    = 1'b0;
    if (mode == MODE_PROBE) begin
      if (found) begin
        present_next    = funcs;
        mode_next       = choose_mode(funcs, funcs);
        push_job.status = STATUS_FOUND;
      end
    end else if (acc) begin
      case (mode)
        MODE_CTRL: begin
          mode_next = choose_mode(present & ~HAS_CTRL, present);
          ok = (hn[0] == CTRL_PAY_LEN) && (hn[4] == FUNC_CTRL_LO);
        end
        MODE_KBD: begin
          mode_next = choose_mode(present & HAS_MOUSE, present);
          ok = (hn[0] == CTRL_PAY_LEN) && (hn[4] == FUNC_KBD_LO);
        end
        default: begin
          mode_next = choose_mode(3'b000, present);
          ok = (hn[0] == MOUSE_PAY_LEN) && (hn[5] == FUNC_MOUSE_HI);
        end
      endcase
      push_job.status = STATUS_ACCEPTED;
      push_job.report = ok && !req.report_busy && is_byte;
    end else begin
      mode_next       = MODE_PROBE;
      push_job.status = STATUS_REJECTED;
    end
  end

  assign push = accept && (!is_byte || req.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_PROBE;
      present <= 3'b000;
      count   <= 7'd0;
      xsum    <= 8'h00;
      lock    <= 1'b0;
    end else begin
      if (accept) begin
        if (!is_byte || req.last) begin
          count <= 7'd0;
          xsum  <= 8'h00;
        end else begin
          count <= count_inc;
          xsum  <= xor_next;
        end
        if (is_byte && req.last) begin
          mode    <= mode_next;
          present <= present_next;
        end
      end
      if (push && push_job.report) lock <= 1'b1;
      else if (report_done) lock <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (accept && is_byte && (count == 7'(i))) hdr[i] <= req.data;
    end
  end

endmodule

@@ hdl/pfc_back.sv @@
// Back part: runs queued jobs, reads the reply store and drives the result register.
module pfc_back import pfc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_empty,
  output logic      pop,
  input  job_t      head,
  input  store_wr_t wr,
  output logic      report_done,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FRAME  = 5'b00010,
    ST_STATUS = 5'b00100,
    ST_FETCH  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  job_t   job;
  job_t   job_next;
  logic [4:0] idx;
  logic [4:0] idx_next;
  logic       borrow;
  logic       borrow_next;
  logic [7:0] rd_data;
  logic [7:0] store [STORE_BYTES];

  logic                can_load;
  logic                load;
  out_item_t           out_next;
  logic [4:0]          rpt_off;
  logic [5:0]          rd_sum;
  logic [STORE_AW-1:0] rd_addr;
  logic [3:0]          frame_len;
  logic [4:0]          rpt_len;
  logic [7:0]          rpt_byte;
  logic                frame_end;
  logic                rpt_end;

  assign can_load = !rsp_valid || rsp_ready;

  // Report byte k comes from store entry 8 + ((k - 1) xor 3).
  assign rpt_off = (idx - 5'd1) ^ 5'd3;
  assign rd_sum  = {1'b0, rpt_off} + RPT_BASE;
  assign rd_addr = STORE_AW'(rd_sum);

  assign frame_len = (job.mode == MODE_PROBE) ? PROBE_FRAME_LEN : COND_FRAME_LEN;
  assign rpt_len   = (job.mode == MODE_MOUSE) ? MOUSE_RPT_LEN : SHORT_RPT_LEN;
  assign frame_end = (idx[3:0] == frame_len - 4'd1);
  assign rpt_end   = (idx == rpt_len - 5'd1);

  always_comb begin
    rpt_byte = rd_data;
    if (idx == 5'd0) begin
      if (job.mode == MODE_CTRL) rpt_byte = RPT_ID_CTRL;
      else if (job.mode == MODE_KBD) rpt_byte = RPT_ID_KBD;
      else rpt_byte = RPT_ID_MOUSE;
    end else if (job.mode == MODE_MOUSE) begin
      // Wheel word is replaced by 0x200 minus itself, low byte first.
      if (idx == 5'd1) rpt_byte = ~rd_data;
      else if (idx == 5'd9) rpt_byte = 8'h00 - rd_data;
      else if (idx == 5'd10) rpt_byte = WHEEL_HI - rd_data - {7'd0, borrow};
    end else if (job.mode == MODE_CTRL) begin
      if (idx inside {5'd1, 5'd2}) rpt_byte = ~rd_data;
      else if (idx inside {[5'd5:5'd8]}) rpt_byte = rd_data ^ SIGN_FLIP;
    end
  end

  always_comb begin
    state_next  = state;
    job_next    = job;
    idx_next    = idx;
    borrow_next = borrow;
    load        = 1'b0;
    pop         = 1'b0;
    report_done = 1'b0;
    out_next    = '0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          job_next   = head;
          idx_next   = 5'd0;
          state_next = head.is_status ? ST_STATUS : ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (can_load) begin
          load                = 1'b1;
          out_next.kind       = KIND_TX;
          out_next.value      = frame_byte(job.mode, idx[3:0]);
          out_next.end_of_run = frame_end;
          if (frame_end) state_next = ST_IDLE;
          else idx_next = idx + 5'd1;
        end
      end
      ST_STATUS: begin
        if (can_load) begin
          load                = 1'b1;
          out_next.kind       = KIND_STATUS;
          out_next.value      = {6'd0, job.status};
          out_next.end_of_run = !job.report;
          state_next          = job.report ? ST_FETCH : ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (can_load) begin
          load                = 1'b1;
          out_next.kind       = KIND_REPORT;
          out_next.value      = rpt_byte;
          out_next.end_of_run = rpt_end;
          if (idx == 5'd9) borrow_next = (rd_data != 8'h00);
          if (rpt_end) begin
            report_done = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            idx_next   = idx + 5'd1;
            state_next = ST_FETCH;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    job    <= job_next;
    idx    <= idx_next;
    borrow <= borrow_next;
    if (load) rsp <= out_next;
  end

  always_ff @(posedge clk) begin
    if (wr.en) store[wr.addr] <= wr.data;
    rd_data <= store[rd_addr];
  end

endmodule
